// File: sv/shc_pkg.sv
`default_nettype none

package shc_pkg;

  // set and table geometry
  localparam int SET_WIDTH   = 64;
  localparam int PLUS_DEPTH  = 32;
  localparam int MINUS_DEPTH = 32;

  // port widths fixed by the item format
  localparam int SET_PORT_W = 64;
  localparam int MATCH_W    = 32;
  localparam int CFG_W      = 7;
  localparam int CFG_IW     = 1;

  // derived widths
  localparam int PLUS_AW     = (PLUS_DEPTH > 1) ? $clog2(PLUS_DEPTH) : 1;
  localparam int MINUS_AW    = (MINUS_DEPTH > 1) ? $clog2(MINUS_DEPTH) : 1;
  localparam int SCAN_DEPTH  = (PLUS_DEPTH > MINUS_DEPTH) ? PLUS_DEPTH : MINUS_DEPTH;
  localparam int SCAN_W      = (SCAN_DEPTH > 1) ? $clog2(SCAN_DEPTH) : 1;
  localparam int CNT_W       = $clog2(SCAN_DEPTH + 1);

  // register indexes
  localparam logic [CFG_IW-1:0] CFG_ATTR = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_PROP = 1'b1;

  // reset values of the registers
  localparam logic [CFG_W-1:0] ATTR_RST = 7'd1;
  localparam logic [CFG_W-1:0] PROP_RST = 7'd0;

  // item operations
  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_PLUS     = 2'd1,
    OP_MINUS    = 2'd2,
    OP_CLASSIFY = 2'd3
  } op_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic scan_en;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
  } sts_t;

endpackage

`default_nettype wire

// File: sv/shc_ram.sv
`default_nettype none

module shc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: sv/shc_ctrl.sv
`default_nettype none

module shc_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [1:0]    op_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output shc_pkg::cmd_t      cmd_o,
  input  wire shc_pkg::sts_t sts_i
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_OUT   = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_load;

  // handshake
  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;

  // commands
  assign cmd_o.accept   = accept;
  assign cmd_o.scan_en  = (state_q == S_SCAN);
  assign cmd_o.out_load = out_load;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (shc_pkg::op_e'(op_i) == shc_pkg::OP_CLASSIFY) ? S_SCAN : S_OUT;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/shc_dp.sv
`default_nettype none

module shc_dp (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [shc_pkg::CFG_IW-1:0]          cfg_index_i,
  input  wire logic [shc_pkg::CFG_W-1:0]           cfg_data_i,
  input  wire logic [1:0]                          op_i,
  input  wire logic [shc_pkg::SET_PORT_W-1:0]      set_bits_i,
  input  wire shc_pkg::cmd_t                       cmd_i,
  output shc_pkg::sts_t                            sts_o,
  output logic                                     status_o,
  output logic      [shc_pkg::MATCH_W-1:0]         plus_match_o,
  output logic      [shc_pkg::MATCH_W-1:0]         minus_match_o,
  output logic      [shc_pkg::SET_PORT_W-1:0]      activity_set_o
);

  localparam int SW = shc_pkg::SET_WIDTH;

  // configuration
  logic [shc_pkg::CFG_W-1:0] attr_q, prop_q;

  // item registers
  shc_pkg::op_e              op_q;
  logic [SW-1:0]             ex_q;
  logic                      status_q;

  // table fill counts
  logic [shc_pkg::CNT_W-1:0] plus_used_q, plus_used_d;
  logic [shc_pkg::CNT_W-1:0] minus_used_q, minus_used_d;

  // scan state
  logic [shc_pkg::SCAN_W-1:0] k_q, rd_idx_q;
  logic                       rd_valid_q;
  logic [shc_pkg::MATCH_W-1:0] pm_q, mm_q;
  logic [SW-1:0]              merged_q;

  // memory ports
  logic                       plus_we, minus_we;
  logic [SW-1:0]              plus_rdata, minus_rdata;

  // match logic
  logic                       plus_hit, minus_hit;
  logic [shc_pkg::MATCH_W-1:0] idx_bit;
  logic                       plus_full, minus_full;
  shc_pkg::op_e               op_in;

  // conflict pair clearing
  logic [SW-1:0]              pair_start;
  logic [SW-1:0]              cleared;
  logic [7:0]                 pair_end;
  logic [7:0]                 attr_w;

  assign op_in      = shc_pkg::op_e'(op_i);
  assign plus_full  = (plus_used_q == shc_pkg::CNT_W'(shc_pkg::PLUS_DEPTH));
  assign minus_full = (minus_used_q == shc_pkg::CNT_W'(shc_pkg::MINUS_DEPTH));
  assign plus_we    = cmd_i.accept && (op_in == shc_pkg::OP_PLUS) && !plus_full;
  assign minus_we   = cmd_i.accept && (op_in == shc_pkg::OP_MINUS) && !minus_full;

  shc_ram #(
    .WIDTH (SW),
    .DEPTH (shc_pkg::PLUS_DEPTH)
  ) u_plus_ram (
    .clk_i   (clk_i),
    .we_i    (plus_we),
    .waddr_i (plus_used_q[shc_pkg::PLUS_AW-1:0]),
    .wdata_i (set_bits_i[SW-1:0]),
    .raddr_i (k_q[shc_pkg::PLUS_AW-1:0]),
    .rdata_o (plus_rdata)
  );

  shc_ram #(
    .WIDTH (SW),
    .DEPTH (shc_pkg::MINUS_DEPTH)
  ) u_minus_ram (
    .clk_i   (clk_i),
    .we_i    (minus_we),
    .waddr_i (minus_used_q[shc_pkg::MINUS_AW-1:0]),
    .wdata_i (set_bits_i[SW-1:0]),
    .raddr_i (k_q[shc_pkg::MINUS_AW-1:0]),
    .rdata_o (minus_rdata)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= shc_pkg::ATTR_RST;
      prop_q <= shc_pkg::PROP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        shc_pkg::CFG_ATTR: attr_q <= cfg_data_i;
        shc_pkg::CFG_PROP: prop_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // fill counts follow clear and append items
  always_comb begin
    plus_used_d  = plus_used_q;
    minus_used_d = minus_used_q;
    if (cmd_i.accept && (op_in == shc_pkg::OP_CLEAR)) begin
      plus_used_d  = '0;
      minus_used_d = '0;
    end
    if (plus_we) begin
      plus_used_d = plus_used_q + 1'b1;
    end
    if (minus_we) begin
      minus_used_d = minus_used_q + 1'b1;
    end
  end

  // scan counter and read pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plus_used_q  <= '0;
      minus_used_q <= '0;
      k_q          <= '0;
      rd_valid_q   <= 1'b0;
    end else begin
      plus_used_q  <= plus_used_d;
      minus_used_q <= minus_used_d;
      rd_valid_q   <= cmd_i.scan_en;
      if (cmd_i.accept) begin
        k_q <= '0;
      end else if (cmd_i.scan_en) begin
        k_q <= k_q + 1'b1;
      end
    end
  end

  assign sts_o.scan_last = (k_q == shc_pkg::SCAN_W'(shc_pkg::SCAN_DEPTH - 1));

  // subset test on the entry read last cycle
  assign plus_hit  = (shc_pkg::CNT_W'(rd_idx_q) < plus_used_q) &&
                     ((plus_rdata & ~ex_q) == '0);
  assign minus_hit = (shc_pkg::CNT_W'(rd_idx_q) < minus_used_q) &&
                     ((minus_rdata & ~ex_q) == '0);
  assign idx_bit   = shc_pkg::MATCH_W'(1) << rd_idx_q;

  // item latch and match accumulation
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q     <= op_in;
      ex_q     <= set_bits_i[SW-1:0];
      status_q <= ((op_in == shc_pkg::OP_PLUS) && plus_full) ||
                  ((op_in == shc_pkg::OP_MINUS) && minus_full);
      pm_q     <= '0;
      mm_q     <= '0;
      merged_q <= '0;
    end else if (rd_valid_q) begin
      if (plus_hit) begin
        pm_q <= pm_q | idx_bit;
      end
      if (minus_hit) begin
        mm_q <= mm_q | idx_bit;
      end
      merged_q <= merged_q | (plus_hit ? plus_rdata : '0) | (minus_hit ? minus_rdata : '0);
    end
    if (cmd_i.scan_en) begin
      rd_idx_q <= k_q;
    end
  end

  // mark pair starts and clear conflicting pairs
  assign attr_w   = {1'b0, attr_q};
  assign pair_end = {1'b0, attr_q} + {1'b0, prop_q};

  always_comb begin
    for (int j = 0; j < SW; j++) begin
      pair_start[j] = (8'(j) >= attr_w) && (8'(j) < pair_end) && (1'(j) == attr_q[0]);
    end
  end

  always_comb begin
    cleared = merged_q;
    for (int j = 0; j < SW - 1; j++) begin
      if (pair_start[j] && merged_q[j] && merged_q[j+1]) begin
        cleared[j]   = 1'b0;
        cleared[j+1] = 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_o <= status_q;
      if (op_q == shc_pkg::OP_CLASSIFY) begin
        plus_match_o   <= pm_q;
        minus_match_o  <= mm_q;
        activity_set_o <= shc_pkg::SET_PORT_W'(ex_q & cleared);
      end else begin
        plus_match_o   <= '0;
        minus_match_o  <= '0;
        activity_set_o <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/subset_hypothesis_classifier.sv
`default_nettype none

// Subset-hypothesis classifier. Items clear both hypothesis tables, append a
// set to the plus or minus table, or classify an example: every stored
// hypothesis that is a subset of the example sets its bit in plus_match or
// minus_match, matching hypotheses are ORed, conflicting property pairs
// (both bits set, pairs counted from attr_count) are cleared, and the result
// is ANDed with the example. Clear and append items go straight from
// acceptance to the result register; a classify item first runs a table
// scan that reads one entry of each table RAM per cycle over all 32 entries,
// then a drain state for the last read, before the result register. One
// item is in work at a time; the result register lets a finished result wait
// for the receiver while the next item is accepted. An append to a full
// table is dropped and reported with status 1. Write attr_count and
// prop_count only while the block is idle.
module subset_hypothesis_classifier (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [shc_pkg::CFG_IW-1:0]         cfg_index_i,
  input  wire logic [shc_pkg::CFG_W-1:0]          cfg_data_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [1:0]                         op_i,
  input  wire logic [shc_pkg::SET_PORT_W-1:0]     set_bits_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic                                    status_o,
  output logic      [shc_pkg::MATCH_W-1:0]        plus_match_o,
  output logic      [shc_pkg::MATCH_W-1:0]        minus_match_o,
  output logic      [shc_pkg::SET_PORT_W-1:0]     activity_set_o
);

  shc_pkg::cmd_t cmd;
  shc_pkg::sts_t sts;

  // sequencing
  shc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // tables, scan and result
  shc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .op_i           (op_i),
    .set_bits_i     (set_bits_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .status_o       (status_o),
    .plus_match_o   (plus_match_o),
    .minus_match_o  (minus_match_o),
    .activity_set_o (activity_set_o)
  );

endmodule

`default_nettype wire

// File: verif/subset_hypothesis_classifier_tb.sv
module subset_hypothesis_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import shc_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 80;
  localparam logic [SET_PORT_W-1:0] SET_MASK = {SET_PORT_W{1'b1}} >> (SET_PORT_W - SET_WIDTH);

  typedef struct {
    op_e                   op;
    logic [SET_PORT_W-1:0] bits;
  } item_t;

  typedef struct {
    logic                  status;
    logic [MATCH_W-1:0]    plus_match;
    logic [MATCH_W-1:0]    minus_match;
    logic [SET_PORT_W-1:0] activity_set;
  } outcome_t;

  // block ports
  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IW-1:0]     cfg_index_i = CFG_ATTR;
  logic [CFG_W-1:0]      cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [1:0]            op_i = OP_CLEAR;
  logic [SET_PORT_W-1:0] set_bits_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  status_o;
  logic [MATCH_W-1:0]    plus_match_o;
  logic [MATCH_W-1:0]    minus_match_o;
  logic [SET_PORT_W-1:0] activity_set_o;

  // items waiting to be sent and outcomes waiting to arrive
  item_t    item_q [$];
  outcome_t outcome_q [$];
  int       sent_cnt = 0;
  int       taken_cnt = 0;
  int       err_cnt = 0;
  int       cyc_cnt = 0;
  int       send_idle_pct = 13;
  int       recv_idle_pct = 46;

  // shadow copy of the hypothesis tables and registers
  logic [SET_WIDTH-1:0] plus_tab [PLUS_DEPTH];
  logic [SET_WIDTH-1:0] minus_tab [MINUS_DEPTH];
  int                   plus_cnt = 0;
  int                   minus_cnt = 0;
  int                   attr_cfg = int'(ATTR_RST);
  int                   prop_cfg = int'(PROP_RST);

  subset_hypothesis_classifier u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .set_bits_i     (set_bits_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .plus_match_o   (plus_match_o),
    .minus_match_o  (minus_match_o),
    .activity_set_o (activity_set_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // apply one item to the shadow tables and work out its outcome
  function automatic outcome_t apply_item(op_e op, logic [SET_PORT_W-1:0] raw);
    outcome_t             r;
    logic [SET_WIDTH-1:0] s;
    logic [SET_WIDTH-1:0] merged;
    int                   lim;
    r.status       = 1'b0;
    r.plus_match   = '0;
    r.minus_match  = '0;
    r.activity_set = '0;
    s      = SET_WIDTH'(raw & SET_MASK);
    merged = '0;
    case (op)
      OP_CLEAR: begin
        plus_cnt  = 0;
        minus_cnt = 0;
      end
      OP_PLUS: begin
        if (plus_cnt < PLUS_DEPTH) begin
          plus_tab[plus_cnt] = s;
          plus_cnt++;
        end else begin
          r.status = 1'b1;
        end
      end
      OP_MINUS: begin
        if (minus_cnt < MINUS_DEPTH) begin
          minus_tab[minus_cnt] = s;
          minus_cnt++;
        end else begin
          r.status = 1'b1;
        end
      end
      default: begin
        // subset test against every stored hypothesis
        for (int k = 0; k < plus_cnt && k < MATCH_W; k++) begin
          if ((plus_tab[k] & ~s) == '0) begin
            r.plus_match[k] = 1'b1;
            merged |= plus_tab[k];
          end
        end
        for (int k = 0; k < minus_cnt && k < MATCH_W; k++) begin
          if ((minus_tab[k] & ~s) == '0) begin
            r.minus_match[k] = 1'b1;
            merged |= minus_tab[k];
          end
        end
        // conflicting property pairs drop out, a pair reaching past the set is left alone
        lim = attr_cfg + prop_cfg;
        for (int i = attr_cfg; i < lim; i += 2) begin
          if (i + 1 < SET_WIDTH) begin
            if (merged[i] && merged[i+1]) begin
              merged[i]   = 1'b0;
              merged[i+1] = 1'b0;
            end
          end
        end
        r.activity_set = SET_PORT_W'(s & merged);
      end
    endcase
    return r;
  endfunction

  function automatic logic [SET_PORT_W-1:0] wide_rand();
    return {$urandom, $urandom};
  endfunction

  // mostly sparse sets so that subsets turn up often
  function automatic logic [SET_PORT_W-1:0] sparse_set();
    logic [SET_PORT_W-1:0] s;
    s = wide_rand() & wide_rand();
    case ($urandom_range(9))
      0: s = '0;
      1: s = '1;
      2, 3: s = s & wide_rand();
      4, 5, 6: s = s & wide_rand() & wide_rand();
      default: ;
    endcase
    return s;
  endfunction

  function automatic void push_item(op_e op, logic [SET_PORT_W-1:0] bits);
    item_t it;
    it.op   = op;
    it.bits = bits;
    item_q.insert(item_q.size(), it);
    sent_cnt++;
  endfunction

  // block until every item is taken and every outcome has arrived
  task automatic wait_idle();
    do @(posedge clk_i);
    while (taken_cnt != sent_cnt || outcome_q.size() != 0);
  endtask

  task automatic write_cfg(logic [CFG_W-1:0] attr, logic [CFG_W-1:0] prop);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_ATTR;
    cfg_data_i  <= attr;
    @(posedge clk_i);
    cfg_index_i <= CFG_PROP;
    cfg_data_i  <= prop;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    attr_cfg = int'(attr);
    prop_cfg = int'(prop);
  endtask

  // clear, fill both tables, then classify examples built from the hypotheses
  task automatic run_session();
    logic [SET_PORT_W-1:0] hyps [$];
    logic [SET_PORT_W-1:0] h;
    logic [SET_PORT_W-1:0] ex;
    int                    n_plus;
    int                    n_minus;
    int                    n_cls;
    push_item(OP_CLEAR, wide_rand());
    n_plus  = ($urandom_range(3) == 0) ? $urandom_range(PLUS_DEPTH - 2, PLUS_DEPTH + 2)
                                       : $urandom_range(0, 8);
    n_minus = ($urandom_range(3) == 0) ? $urandom_range(MINUS_DEPTH - 2, MINUS_DEPTH + 2)
                                       : $urandom_range(0, 8);
    n_cls   = $urandom_range(4, 12);
    while (n_plus + n_minus > 0) begin
      h = sparse_set();
      if (n_minus == 0 || (n_plus != 0 && $urandom_range(1) == 0)) begin
        push_item(OP_PLUS, h);
        n_plus--;
      end else begin
        push_item(OP_MINUS, h);
        n_minus--;
      end
      hyps.insert(hyps.size(), h);
    end
    for (int c = 0; c < n_cls; c++) begin
      ex = sparse_set();
      foreach (hyps[j]) begin
        if ($urandom_range(2) == 0) ex |= hyps[j];
      end
      case ($urandom_range(9))
        0: ex = '1;
        1: ex = wide_rand();
        default: ;
      endcase
      push_item(OP_CLASSIFY, ex);
    end
  endtask

  // driver: predict on acceptance, then present the next pending item
  always @(posedge clk_i) begin : drive
    item_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        outcome_q.insert(outcome_q.size(), apply_item(op_e'(op_i), set_bits_i));
        taken_cnt++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (item_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = item_q.pop_front();
          op_i       <= nxt.op;
          set_bits_i <= nxt.bits;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result item with the oldest outcome
  always @(posedge clk_i) begin : watch
    outcome_t w;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (outcome_q.size() == 0) begin
          $error("result item with no outcome pending");
          err_cnt++;
        end else begin
          w = outcome_q.pop_front();
          if (status_o !== w.status) begin
            $error("status: expected %0h, got %0h", w.status, status_o);
            err_cnt++;
          end
          if (plus_match_o !== w.plus_match) begin
            $error("plus_match: expected %h, got %h", w.plus_match, plus_match_o);
            err_cnt++;
          end
          if (minus_match_o !== w.minus_match) begin
            $error("minus_match: expected %h, got %h", w.minus_match, minus_match_o);
            err_cnt++;
          end
          if (activity_set_o !== w.activity_set) begin
            $error("activity_set: expected %h, got %h", w.activity_set, activity_set_o);
            err_cnt++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == CYCLE_LIMIT) begin
      $display("FAIL subset_hypothesis_classifier");
      $finish;
    end
  end

  // stimulus
  initial begin : stim
    int                target;
    logic [CFG_W-1:0]  attr;
    logic [CFG_W-1:0]  prop;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset register values, empty tables, empty hypothesis, extreme sets
    push_item(OP_CLASSIFY, '1);
    push_item(OP_PLUS, '0);
    push_item(OP_PLUS, '1);
    push_item(OP_MINUS, {(SET_PORT_W/2){2'b10}});
    push_item(OP_MINUS, {(SET_PORT_W/2){2'b01}});
    push_item(OP_CLASSIFY, '0);
    push_item(OP_CLASSIFY, '1);
    push_item(OP_CLASSIFY, {(SET_PORT_W/2){2'b10}});
    push_item(OP_CLASSIFY, {(SET_PORT_W/2){2'b01}});
    push_item(OP_CLEAR, '1);
    push_item(OP_CLASSIFY, '1);
    push_item(OP_MINUS, '0);
    push_item(OP_PLUS, {1'b1, {(SET_PORT_W-2){1'b0}}, 1'b1});
    push_item(OP_CLASSIFY, {1'b1, {(SET_PORT_W-2){1'b0}}, 1'b1});

    // odd property count, conflicts across both tables and past the range
    wait_idle();
    write_cfg(7'd2, 7'd5);
    push_item(OP_CLEAR, '0);
    push_item(OP_PLUS, 64'h0000_0000_0000_00fc);
    push_item(OP_MINUS, 64'h0000_0000_0000_0003);
    push_item(OP_MINUS, 64'h0000_0000_0000_0014);
    push_item(OP_CLASSIFY, '1);
    push_item(OP_CLASSIFY, 64'h0000_0000_0000_00f7);
    push_item(OP_CLASSIFY, 64'h0000_0000_0000_0017);

    // random phases over register settings and idle patterns
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0: begin attr = 7'd0;   prop = 7'd64;  end
        1: begin attr = 7'd64;  prop = 7'd64;  end
        2: begin attr = 7'd1;   prop = 7'd63;  end
        3: begin attr = 7'd63;  prop = 7'd1;   end
        4: begin attr = 7'd32;  prop = 7'd31;  end
        5: begin attr = 7'd127; prop = 7'd127; end
        6: begin attr = 7'd1;   prop = 7'd0;   end
        7: begin attr = 7'($urandom_range(127)); prop = 7'($urandom_range(127)); end
        default: begin attr = 7'd2; prop = 7'd62; end
      endcase
      write_cfg(attr, prop);
      case (p / 3)
        0: begin send_idle_pct = 13; recv_idle_pct = 46; end
        1: begin send_idle_pct = 46; recv_idle_pct = 13; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      target = sent_cnt + PHASE_ITEMS;
      while (sent_cnt < target) begin
        run_session();
        // occasional stray items break up the sequences
        if ($urandom_range(2) == 0) begin
          repeat ($urandom_range(1, 3)) push_item(op_e'($urandom_range(3)), wide_rand());
        end
      end
    end

    // drain
    wait_idle();
    repeat (50) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("PASS subset_hypothesis_classifier");
    end else begin
      $display("FAIL subset_hypothesis_classifier");
    end
    $finish;
  end

endmodule
